@@ rtl/core/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
	localparam int WORD_BITS = 32;
	localparam int MAG_BITS  = 2 * WORD_BITS;
	localparam int CNT_BITS  = $clog2(MAG_BITS + 1);

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_NORM = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DIV1, S_DIV2, S_CHECK, S_OUT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic comb;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic div_sel_den;
		logic check;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic in_err;
		logic num_zero;
		logic gcd_done;
		logic div_done;
	} sts_t;
endpackage

@@ rtl/core/rau_datapath.sv @@
// Datapath: operand load, products, sum, binary gcd and restoring dividers.
`timescale 1ns / 1ps
module rau_datapath
	import rau_pkg::*;
(
	input  logic                        clk,
	input  cmd_t                        cmd,
	input  logic [2:0]                  opcode,
	input  logic [WORD_BITS-1:0]        a_num,
	input  logic [WORD_BITS-1:0]        a_den,
	input  logic [WORD_BITS-1:0]        b_num,
	input  logic [WORD_BITS-1:0]        b_den,
	output sts_t                        sts,
	output logic signed [WORD_BITS-1:0] res_num,
	output logic [WORD_BITS-2:0]        res_den,
	output logic [1:0]                  status
);
	logic [2:0]          op_q;
	logic [WORD_BITS:0]  an_q, ad_q, bn_q, bd_q; // magnitudes, up to 2^(W-1)
	logic                ans_q, ads_q, bns_q, bds_q;
	logic [MAG_BITS-1:0] p1_q, p2_q, num_q, den_q;
	logic                p1s_q, p2s_q, nums_q, dens_q;
	logic [MAG_BITS-1:0] gx_q, gy_q;
	logic [CNT_BITS-1:0] gsh_q;
	logic [MAG_BITS-1:0] quo_q, rem_q, dvs_q;
	logic [CNT_BITS-1:0] dcnt_q;
	logic [MAG_BITS-1:0] qn_q;
	logic                binop;

	function automatic logic [WORD_BITS:0] mag_of(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS:0] e;
		e = {v[WORD_BITS-1], v};
		return v[WORD_BITS-1] ? (~e + 1'b1) : e;
	endfunction

	assign binop = (op_q <= 3'd3);
	assign sts.in_err = (ad_q == '0) || (binop && bd_q == '0) ||
		(op_q == OP_DIV && bn_q == '0);
	assign sts.num_zero = (num_q == '0);
	assign sts.gcd_done = (gy_q == '0);
	assign sts.div_done = (dcnt_q == '0);

	// Product operand selection per step.
	logic [WORD_BITS:0] m1a, m1b, m2a, m2b;
	logic               m1s, m2s;
	always_comb begin
		m1a = an_q; m1b = bd_q; m1s = ans_q ^ bds_q;
		m2a = bn_q; m2b = ad_q; m2s = bns_q ^ ads_q;
		case (op_q)
			OP_ADD: ;
			OP_SUB: m2s = ~(bns_q ^ ads_q);
			OP_MUL: begin
				m1b = bn_q; m1s = ans_q ^ bns_q;
				m2a = ad_q; m2b = bd_q; m2s = ads_q ^ bds_q;
			end
			OP_DIV: begin
				m2a = ad_q; m2b = bn_q; m2s = ads_q ^ bns_q;
			end
			default: ;
		endcase
	end
	logic [MAG_BITS-1:0] den_prod;
	logic                den_prod_s;
	assign den_prod   = (op_q == OP_DIV) ? p2_q : MAG_BITS'(ad_q) * MAG_BITS'(bd_q);
	assign den_prod_s = (op_q == OP_DIV) ? p2s_q : (ads_q ^ bds_q);

	// Binary gcd step: subtract-and-shift on x >= y ordering.
	logic [MAG_BITS-1:0] gdiff;
	assign gdiff = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;

	// Restoring division step.
	logic [MAG_BITS:0]   trem;
	assign trem = {rem_q, quo_q[MAG_BITS-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			an_q <= mag_of(a_num); ans_q <= a_num[WORD_BITS-1];
			ad_q <= mag_of(a_den); ads_q <= a_den[WORD_BITS-1];
			bn_q <= mag_of(b_num); bns_q <= b_num[WORD_BITS-1];
			bd_q <= mag_of(b_den); bds_q <= b_den[WORD_BITS-1];
			status <= ST_OK; res_num <= '0; res_den <= '0;
		end
		if (cmd.mul1) begin
			p1_q <= MAG_BITS'(m1a) * MAG_BITS'(m1b);
			p1s_q <= m1s;
		end
		if (cmd.mul2) begin
			p2_q <= MAG_BITS'(m2a) * MAG_BITS'(m2b);
			p2s_q <= m2s;
			if (op_q > OP_DIV) begin
				p1_q <= MAG_BITS'(an_q); p1s_q <= ans_q;
			end
		end
		if (cmd.comb) begin
			if (op_q <= OP_SUB) begin
				if (p1s_q == p2s_q || p2_q == '0) begin
					num_q <= p1_q + p2_q; nums_q <= p1s_q;
				end else if (p1_q >= p2_q) begin
					num_q <= p1_q - p2_q; nums_q <= p1s_q;
				end else begin
					num_q <= p2_q - p1_q; nums_q <= p2s_q;
				end
				den_q <= den_prod; dens_q <= den_prod_s;
			end else if (op_q > OP_DIV) begin
				num_q <= p1_q; nums_q <= p1s_q;
				den_q <= MAG_BITS'(ad_q); dens_q <= ads_q;
			end else if (op_q == OP_MUL) begin
				num_q <= p1_q; nums_q <= p1s_q;
				den_q <= p2_q; dens_q <= p2s_q;
			end else begin
				num_q <= p1_q; nums_q <= p1s_q;
				den_q <= den_prod; dens_q <= den_prod_s;
			end
			gx_q <= '0; gy_q <= '1; gsh_q <= '0;
		end
		if (cmd.gcd_step) begin
			if (gx_q == '0 && gy_q == '1 && gsh_q == '0) begin
				gx_q <= num_q; gy_q <= den_q;
			end else if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gsh_q <= gsh_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else begin
				gx_q <= (gx_q < gy_q) ? gx_q : gy_q;
				gy_q <= gdiff >> 1;
			end
		end
		if (cmd.div_init) begin
			quo_q <= cmd.div_sel_den ? den_q : num_q;
			rem_q <= '0;
			dvs_q <= gx_q << gsh_q;
			dcnt_q <= CNT_BITS'(MAG_BITS);
		end
		if (cmd.div_step) begin
			if (!trem[MAG_BITS]) begin
				rem_q <= trem[MAG_BITS-1:0];
				quo_q <= {quo_q[MAG_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[MAG_BITS-2:0], quo_q[MAG_BITS-1]};
				quo_q <= {quo_q[MAG_BITS-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (cmd.div_init && cmd.div_sel_den)
			qn_q <= quo_q;
		if (cmd.check) begin
			if (sts.in_err) begin
				status <= ST_ZERO;
			end else if (sts.num_zero) begin
				res_num <= '0; res_den <= (WORD_BITS-1)'(1);
			end else if (quo_q > MAG_BITS'({1'b0, {(WORD_BITS-1){1'b1}}}) ||
				((nums_q ^ dens_q) ? qn_q > (MAG_BITS'(1) << (WORD_BITS-1))
				: qn_q > MAG_BITS'({1'b0, {(WORD_BITS-1){1'b1}}}))) begin
				status <= ST_OVF;
			end else begin
				res_num <= (nums_q ^ dens_q) ? WORD_BITS'(~qn_q + 1'b1) : WORD_BITS'(qn_q);
				res_den <= quo_q[WORD_BITS-2:0];
			end
		end
	end
endmodule

@@ rtl/core/rau_ctrl.sv @@
// Controller state machine sequencing the datapath.
`timescale 1ns / 1ps
module rau_ctrl
	import rau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic out_taken,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic out_valid
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_MUL1;
			S_MUL1:  state_d = sts.in_err ? S_CHECK : S_MUL2;
			S_MUL2:  state_d = S_COMB;
			S_COMB:  state_d = S_GCD;
			S_GCD:   if (sts.num_zero) state_d = S_CHECK;
				else if (sts.gcd_done) state_d = S_DIV1;
			S_DIV1:  if (sts.div_done) state_d = S_DIV2;
			S_DIV2:  if (sts.div_done) state_d = S_CHECK;
			S_CHECK: state_d = S_OUT;
			S_OUT:   if (out_taken) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// High for the first cycle spent in a state.
	logic first_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b0;
		else first_q <= (state_q != state_d);
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load = start;
			S_MUL1:  cmd.mul1 = 1'b1;
			S_MUL2:  cmd.mul2 = 1'b1;
			S_COMB:  cmd.comb = 1'b1;
			S_GCD: begin
				cmd.gcd_step = !sts.gcd_done || first_q;
				cmd.div_init = sts.gcd_done && !first_q;
			end
			S_DIV1: begin
				cmd.div_step = !sts.div_done;
				cmd.div_init = sts.div_done;
				cmd.div_sel_den = sts.div_done;
			end
			S_DIV2:  cmd.div_step = !sts.div_done;
			S_CHECK: cmd.check = 1'b1;
			default: ;
		endcase
	end
	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule

@@ rtl/core/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit.
`timescale 1ns / 1ps
// Exact rational arithmetic on signed 32-bit fractions with gcd reduction.
// Input channel s_axis: one transaction carries opcode and operands a, b.
//   opcode 0 add, 1 subtract, 2 multiply, 3 divide, 4..7 normalize a.
// Output channel m_axis: one transaction per input, reduced res_num /
//   res_den and status (0 ok, 1 zero denominator, 2 overflow).
// One item at a time: s_axis_tready is high only while the unit is idle.
// Sequence: the product and sum steps, the binary gcd loop, then two
//   restoring divisions by the gcd (numerator first, then denominator) and
//   a check before the result is offered on m_axis.
// A zero-denominator input goes from the first product step to the check,
//   skipping the loop; a zero numerator skips the divisions.
// When the receiver stalls, hold the result in the output register until
//   m_axis_tready; no new item is taken meanwhile.
// Reset clears the controller to idle; no result is pending after reset.
module rational_arithmetic_unit
	import rau_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// opcode[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], pad
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// res_num[31:0], res_den[62:32], status[64:63], pad
	output logic [71:0]  m_axis_tdata
);
	cmd_t cmd;
	sts_t sts;
	logic busy;
	logic signed [WORD_BITS-1:0] res_num;
	logic [WORD_BITS-2:0] res_den;
	logic [1:0] status;

	assign s_axis_tready = !busy;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.start(s_axis_tvalid && !busy),
		.out_taken(m_axis_tready),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
	);

	rau_datapath u_dp (
		.clk(clk), .cmd(cmd),
		.opcode(s_axis_tdata[2:0]),
		.a_num(s_axis_tdata[34:3]), .a_den(s_axis_tdata[66:35]),
		.b_num(s_axis_tdata[98:67]), .b_den(s_axis_tdata[130:99]),
		.sts(sts), .res_num(res_num), .res_den(res_den), .status(status)
	);

	assign m_axis_tdata = {7'd0, status, res_den, res_num};

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[64:63] != 2'd0) |-> m_axis_tdata[62:0] == '0)
		else $error("error result not cleared");
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[64:63] == 2'd0) |-> m_axis_tdata[62:32] != '0)
		else $error("ok result with zero denominator");
`endif
endmodule
